// File: hdl/itoa_pkg.sv
// itoa_pkg: shared types, character constants and helpers for the integer to ascii formatter
// depends on nothing; imported by the digit unit and the formatter
`default_nettype none

package itoa_pkg;

  // column limit for the minimum width field
  localparam int MAX_WIDTH  = 63;
  // digit buffer depth: eleven octal digits plus a slot for the minus sign
  localparam int DIGIT_MAX  = 12;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] LETTER_GAP = 8'h07;  // 'A' - '0' - 10
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // ceil(2^35 / 10), quotient by ten is (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SH  = 35;

  // radix selector codes, the unused code decodes as hexadecimal
  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  // one step of the digit unit
  typedef struct packed {
    logic [31:0] quot;
    logic [3:0]  digit;
  } digit_res_t;

  // ascii character of one digit value
  function automatic logic [7:0] digit_to_char(input logic [3:0] d, input logic lower);
    logic [7:0] ch;
    ch = CH_ZERO + {4'd0, d};
    if (d >= 4'd10) begin
      ch = ch + LETTER_GAP + (lower ? CASE_BIT : 8'd0);
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hdl/itoa_digit_unit.sv
// itoa_digit_unit: shared divide-by-radix unit
// depends on itoa_pkg; the base-ten reciprocal product is registered
`default_nettype none

module itoa_digit_unit
  import itoa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [31:0] dividend,
  input  wire radix_t     radix,
  output digit_res_t      res
);

  logic [63:0] prod;
  logic [31:0] q10;
  logic [31:0] r10;

  // reciprocal product of the held dividend, used in the next cycle
  always_ff @(posedge clk) begin
    prod <= 64'(dividend) * 64'(RECIP10);
  end

  // quotient and remainder for base ten
  assign q10 = 32'(prod[63:RECIP_SH]);
  assign r10 = dividend - ((q10 << 3) + (q10 << 1));

  // select by radix, octal and hex are plain shifts
  always_comb begin
    unique case (radix)
      RADIX_OCT: begin
        res.quot  = dividend >> 3;
        res.digit = {1'b0, dividend[2:0]};
      end
      RADIX_DEC: begin
        res.quot  = q10;
        res.digit = r10[3:0];
      end
      default: begin
        res.quot  = dividend >> 4;
        res.digit = dividend[3:0];
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: one 32-bit value in, its ascii characters out, one per beat
// sequence: each digit takes a multiply step and a remainder step in the shared digit unit (up to 11
// digits), then a sign step and a fill step, and the fill and digit characters go out one per beat
// a new item is taken only in idle; the last character may still wait in the output register
// reset: synchronous active-high rst returns to idle and empties the output register
`default_nettype none

module integer_to_ascii_formatter
  import itoa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: value[31:0], min_width[37:32], pad_char[45:38], zeros[47:46]
  input  wire logic [47:0] s_tdata,
  // s_tuser: radix_sel[1:0], lower_case[2], is_signed[3]
  input  wire logic [3:0]  s_tuser,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // m_tdata: char_out[7:0]
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_SIGN,
    S_PAD,
    S_DIGIT
  } state_t;

  localparam logic [3:0] LEN_LAST  = 4'(DIGIT_MAX - 1);
  localparam logic [5:0] WIDTH_SAT = 6'(MAX_WIDTH);

  state_t      state;
  logic [31:0] cur;
  radix_t      radix;
  logic        lower;
  logic        neg;
  logic [5:0]  width;
  logic [7:0]  fill;
  logic [3:0]  len;
  logic [7:0]  dbuf [DIGIT_MAX];

  digit_res_t  res;
  logic        out_free;
  logic        out_load;
  logic [31:0] in_value;
  logic [5:0]  in_width;
  logic        in_neg;

  itoa_digit_unit u_digit (
    .clk      (clk),
    .dividend (cur),
    .radix    (radix),
    .res      (res)
  );

  // input field decode
  assign in_value = s_tdata[31:0];
  assign in_neg   = s_tuser[3] & in_value[31];
  assign in_width = (s_tdata[37:32] > WIDTH_SAT) ? WIDTH_SAT : s_tdata[37:32];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // a new beat goes into the output register this cycle
  assign out_load = out_free &&
                    (((state == S_SIGN) && neg && (fill != CH_SPACE)) ||
                     ((state == S_PAD) && (width > {2'b00, len})) ||
                     (state == S_DIGIT));

  // sequencer, digit buffer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur   <= in_neg ? (32'd0 - in_value) : in_value;
            radix <= radix_t'(s_tuser[1:0]);
            lower <= s_tuser[2];
            neg   <= in_neg;
            width <= in_width;
            fill  <= s_tdata[45:38];
            len   <= 4'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_REM;
        end
        S_REM: begin
          dbuf[len] <= digit_to_char(res.digit, lower);
          len       <= len + 4'd1;
          cur       <= res.quot;
          if (res.quot != 32'd0 && len < LEN_LAST) begin
            state <= S_MUL;
          end else begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!neg) begin
            state <= S_PAD;
          end else if (fill == CH_SPACE) begin
            // sign sits right before the digits and counts toward the width
            dbuf[len] <= CH_MINUS;
            len       <= len + 4'd1;
            state     <= S_PAD;
          end else if (out_free) begin
            // sign goes first and uses up one column
            m_tdata  <= CH_MINUS;
            m_tlast  <= 1'b0;
            m_tvalid <= 1'b1;
            if (width != 6'd0) begin
              width <= width - 6'd1;
            end
            state <= S_PAD;
          end
        end
        S_PAD: begin
          if (width > {2'b00, len}) begin
            if (out_free) begin
              m_tdata  <= fill;
              m_tlast  <= 1'b0;
              m_tvalid <= 1'b1;
              width    <= width - 6'd1;
            end
          end else begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (out_free) begin
            m_tdata  <= dbuf[len - 4'd1];
            m_tlast  <= (len == 4'd1);
            m_tvalid <= 1'b1;
            len      <= len - 4'd1;
            if (len == 4'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/itoa_checker.sv
// itoa_checker: port-level assertions for the integer to ascii formatter
// depends on nothing but the top level's ports; bound to integer_to_ascii_formatter below
`default_nettype none

module itoa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready
);

  // a stalled output beat holds its character and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // an accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // a new item is only taken once all but the final character have gone
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
    else $error("new item accepted while a previous item is still emitting");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire
